/* sv/dqm_pkg.sv */
`default_nettype none
package dqm_pkg;

  localparam int IN_W    = 16;
  localparam int OUT_W   = 24;
  localparam int SUM_W   = 33;            // w*w+x*x+y*y+z*z, unsigned
  localparam int NUM_W   = 35;            // numerators, signed
  localparam int MAG_W   = 34;            // |numerator|
  localparam int DIV2_W  = SUM_W + 1;     // 2*S
  localparam int QBITS   = 25;            // quotient bits kept, q < 2^25
  localparam int REM_W   = DIV2_W + QBITS;
  localparam int FRAC    = 15;

  localparam logic [1:0] COL_TRANS = 2'd3;
  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;
  localparam logic [OUT_W-1:0] ONE_VAL = 24'h008000;

  typedef struct packed {
    logic signed [IN_W-1:0] real_w;
    logic signed [IN_W-1:0] real_x;
    logic signed [IN_W-1:0] real_y;
    logic signed [IN_W-1:0] real_z;
    logic signed [IN_W-1:0] dual_w;
    logic signed [IN_W-1:0] dual_x;
    logic signed [IN_W-1:0] dual_y;
    logic signed [IN_W-1:0] dual_z;
  } in_t;

  typedef struct packed {
    logic [1:0]              column_index;
    logic signed [OUT_W-1:0] row0_value;
    logic signed [OUT_W-1:0] row1_value;
    logic signed [OUT_W-1:0] row2_value;
    logic                    last_column;
    logic                    degenerate;
    logic                    saturated;
  } out_t;

  // all numerators of one transaction, column major
  typedef struct packed {
    logic [SUM_W-1:0]             s;
    logic [3:0][2:0][NUM_W-1:0]   num;
    logic                         degen;
  } num_t;

  // one column handed to the divider
  typedef struct packed {
    logic [1:0]                 col;
    logic                       degen;
    logic [SUM_W-1:0]           s;
    logic [2:0][NUM_W-1:0]      num;
  } dreq_t;

  typedef struct packed {
    logic [1:0]                 col;
    logic                       degen;
    logic [DIV2_W-1:0]          div2;
    logic [2:0][REM_W-1:0]      rem;
    logic [2:0][QBITS-1:0]      q;
    logic [2:0]                 neg;
    logic [2:0]                 ovf;
  } dstg_t;

endpackage
`default_nettype wire

/* sv/dqm_if.sv */
`default_nettype none
interface dqm_in_if;
  logic          valid;
  logic          ready;
  dqm_pkg::in_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dqm_out_if;
  logic          valid;
  logic          ready;
  dqm_pkg::out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/dqm_front.sv */
`default_nettype none
// products, then sums; two stages with their own valid bits
module dqm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dqm_pkg::in_t  in_data,
  output logic               num_valid,
  input  wire logic          num_take,
  output dqm_pkg::num_t      num_data
);

  logic v1_r, v2_r, mv1, mv2;
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [31:0] dwx_r, wdx_r, dyz_r, dzy_r, dwy_r, wdy_r, dzx_r, dxz_r;
  logic signed [31:0] dwz_r, wdz_r, dxy_r, dyx_r;
  dqm_pkg::num_t num_r, num_nxt;

  function automatic logic signed [dqm_pkg::NUM_W-1:0] sx(input logic signed [31:0] v);
    sx = {{(dqm_pkg::NUM_W-32){v[31]}}, v};
  endfunction

  assign mv2      = !v2_r || num_take;
  assign mv1      = !v1_r || mv2;
  assign in_ready = mv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (mv1) v1_r <= in_valid;
      if (mv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1 && in_valid) begin
      ww_r  <= in_data.real_w * in_data.real_w;
      xx_r  <= in_data.real_x * in_data.real_x;
      yy_r  <= in_data.real_y * in_data.real_y;
      zz_r  <= in_data.real_z * in_data.real_z;
      xy_r  <= in_data.real_x * in_data.real_y;
      wz_r  <= in_data.real_w * in_data.real_z;
      xz_r  <= in_data.real_x * in_data.real_z;
      wy_r  <= in_data.real_w * in_data.real_y;
      yz_r  <= in_data.real_y * in_data.real_z;
      wx_r  <= in_data.real_w * in_data.real_x;
      dwx_r <= in_data.dual_w * in_data.real_x;
      wdx_r <= in_data.real_w * in_data.dual_x;
      dyz_r <= in_data.dual_y * in_data.real_z;
      dzy_r <= in_data.dual_z * in_data.real_y;
      dwy_r <= in_data.dual_w * in_data.real_y;
      wdy_r <= in_data.real_w * in_data.dual_y;
      dzx_r <= in_data.dual_z * in_data.real_x;
      dxz_r <= in_data.dual_x * in_data.real_z;
      dwz_r <= in_data.dual_w * in_data.real_z;
      wdz_r <= in_data.real_w * in_data.dual_z;
      dxy_r <= in_data.dual_x * in_data.real_y;
      dyx_r <= in_data.dual_y * in_data.real_x;
    end
  end

  always_comb begin
    num_nxt.s = {1'b0, ww_r[31:0]} + {1'b0, xx_r[31:0]}
              + {1'b0, yy_r[31:0]} + {1'b0, zz_r[31:0]};
    num_nxt.degen = (num_nxt.s == '0);
    num_nxt.num[0][0] = sx(ww_r) + sx(xx_r) - sx(yy_r) - sx(zz_r);
    num_nxt.num[0][1] = (sx(xy_r) + sx(wz_r)) <<< 1;
    num_nxt.num[0][2] = (sx(xz_r) - sx(wy_r)) <<< 1;
    num_nxt.num[1][0] = (sx(xy_r) - sx(wz_r)) <<< 1;
    num_nxt.num[1][1] = sx(ww_r) + sx(yy_r) - sx(xx_r) - sx(zz_r);
    num_nxt.num[1][2] = (sx(yz_r) + sx(wx_r)) <<< 1;
    num_nxt.num[2][0] = (sx(xz_r) + sx(wy_r)) <<< 1;
    num_nxt.num[2][1] = (sx(yz_r) - sx(wx_r)) <<< 1;
    num_nxt.num[2][2] = sx(ww_r) + sx(zz_r) - sx(xx_r) - sx(yy_r);
    num_nxt.num[3][0] = (sx(wdx_r) - sx(dwx_r) - sx(dyz_r) + sx(dzy_r)) <<< 1;
    num_nxt.num[3][1] = (sx(wdy_r) - sx(dwy_r) - sx(dzx_r) + sx(dxz_r)) <<< 1;
    num_nxt.num[3][2] = (sx(wdz_r) - sx(dwz_r) - sx(dxy_r) + sx(dyx_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (mv2 && v1_r) num_r <= num_nxt;
  end

  assign num_valid = v2_r;
  assign num_data  = num_r;

endmodule
`default_nettype wire

/* sv/dqm_divider.sv */
`default_nettype none
// three-lane restoring divider, one quotient bit per stage
// q = floor((|num|*2^16 + S) / (2*S)), ovf when q would not fit QBITS
module dqm_divider (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           req_valid,
  input  wire dqm_pkg::dreq_t req,
  output logic                res_valid,
  output dqm_pkg::dstg_t      res
);

  localparam int QB = dqm_pkg::QBITS;

  dqm_pkg::dstg_t pre_r, pre_nxt;
  logic           pre_v_r;
  dqm_pkg::dstg_t st_r [QB+1];
  logic [QB:0]    v_r;
  dqm_pkg::dstg_t st0_nxt;

  always_comb begin
    logic [dqm_pkg::NUM_W-1:0] a;
    logic [dqm_pkg::MAG_W-1:0] mag;
    pre_nxt      = '0;
    pre_nxt.col  = req.col;
    pre_nxt.degen = req.degen;
    pre_nxt.div2 = {req.s, 1'b0};
    for (int r = 0; r < 3; r++) begin
      a = req.num[r];
      pre_nxt.neg[r] = a[dqm_pkg::NUM_W-1];
      mag = a[dqm_pkg::NUM_W-1] ? dqm_pkg::MAG_W'(-a) : a[dqm_pkg::MAG_W-1:0];
      pre_nxt.rem[r] = dqm_pkg::REM_W'({mag, 16'b0}) + dqm_pkg::REM_W'(req.s);
    end
  end

  always_comb begin
    st0_nxt = pre_r;
    for (int r = 0; r < 3; r++)
      st0_nxt.ovf[r] = (pre_r.rem[r] >= {pre_r.div2, {QB{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
      v_r     <= '0;
    end else if (adv) begin
      pre_v_r <= req_valid;
      v_r     <= {v_r[QB-1:0], pre_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r    <= pre_nxt;
      st_r[0]  <= st0_nxt;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stg
    dqm_pkg::dstg_t stg_nxt;
    always_comb begin
      logic [dqm_pkg::REM_W-1:0] trial;
      stg_nxt = st_r[k];
      trial = {{QB{1'b0}}, st_r[k].div2} << (QB - 1 - k);
      for (int r = 0; r < 3; r++) begin
        if (st_r[k].rem[r] >= trial) begin
          stg_nxt.rem[r] = st_r[k].rem[r] - trial;
          stg_nxt.q[r][QB-1-k] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st_r[k+1] <= stg_nxt;
    end
  end

  assign res_valid = v_r[QB];
  assign res       = st_r[QB];

endmodule
`default_nettype wire

/* sv/dual_quaternion_to_matrix.sv */
// Path: front-end products and sums, column serializer, divider pre-stage and quotient
// stages, output register. Columns leave one per cycle unless the output stalls
// (rotation 0, 1, 2, translation). The serializer feeds the three-lane divider one
// column per cycle while not stalled; a new transaction loads after the last column.
// Reset: synchronous, active low rst_n clears all valid bits; data regs are not reset.
`default_nettype none
module dual_quaternion_to_matrix (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dqm_in_if.sink     in_ch,
  dqm_out_if.source  out_ch
);

  // whole back end moves together unless the output register is stuck
  logic adv;

  logic          num_valid, num_take;
  dqm_pkg::num_t num_data;

  // serializer: holds one transaction and walks its four columns
  logic          ser_v_r;
  logic [1:0]    col_r;
  dqm_pkg::num_t ser_r;
  logic          load;

  dqm_pkg::dreq_t req;
  logic           res_valid;
  dqm_pkg::dstg_t res;

  logic          out_v_r;
  dqm_pkg::out_t out_r, out_nxt;

  assign adv      = !out_v_r || out_ch.ready;
  assign load     = adv && (!ser_v_r || col_r == dqm_pkg::COL_TRANS);
  assign num_take = load;

  dqm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .num_valid (num_valid),
    .num_take  (num_take),
    .num_data  (num_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      col_r   <= 2'd0;
    end else if (load) begin
      ser_v_r <= num_valid;
      col_r   <= 2'd0;
    end else if (adv && ser_v_r) begin
      col_r   <= col_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && num_valid) ser_r <= num_data;
  end

  always_comb begin
    req.col   = col_r;
    req.degen = ser_r.degen;
    req.s     = ser_r.s;
    req.num   = ser_r.num[col_r];
  end

  dqm_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req_valid (ser_v_r),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  // sign restore, saturation, identity override for a zero real part
  always_comb begin
    logic [2:0][dqm_pkg::OUT_W-1:0] v;
    logic [2:0] sat;
    logic [dqm_pkg::QBITS-1:0] q;
    for (int r = 0; r < 3; r++) begin
      q = res.q[r];
      sat[r] = 1'b0;
      if (res.degen) begin
        v[r] = (res.col == 2'(r)) ? dqm_pkg::ONE_VAL : '0;
      end else if (!res.neg[r] && (res.ovf[r] || q > dqm_pkg::QBITS'(dqm_pkg::OUT_MAX))) begin
        v[r] = dqm_pkg::OUT_MAX;
        sat[r] = 1'b1;
      end else if (res.neg[r] && (res.ovf[r] || q > dqm_pkg::QBITS'(dqm_pkg::OUT_MIN))) begin
        v[r] = dqm_pkg::OUT_MIN;
        sat[r] = 1'b1;
      end else begin
        v[r] = res.neg[r] ? -q[dqm_pkg::OUT_W-1:0] : q[dqm_pkg::OUT_W-1:0];
      end
    end
    out_nxt.column_index = res.col;
    out_nxt.row0_value   = v[0];
    out_nxt.row1_value   = v[1];
    out_nxt.row2_value   = v[2];
    out_nxt.last_column  = (res.col == dqm_pkg::COL_TRANS);
    out_nxt.degenerate   = res.degen;
    out_nxt.saturated    = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // an idle serializer always restarts at column 0
  a_ser_idle_col0: assert property (@(posedge clk) disable iff (!rst_n)
    !ser_v_r |-> col_r == 2'd0) else $error("serializer idle off column 0");

  // a stalled result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_r))
    else $error("stalled result changed");

  // identity columns are never flagged as clipped
  a_degen_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.degenerate |-> !out_r.saturated)
    else $error("degenerate column flagged saturated");

  // a front-end item stays valid until the serializer takes it
  a_front_flow: assert property (@(posedge clk) disable iff (!rst_n)
    num_valid && !load |=> num_valid) else $error("front end item lost");

endmodule
`default_nettype wire

/* dv/tb_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none
package dqm_tb_pkg;
  // expected contents of one result column
  typedef struct {
    logic [1:0]                 column_index;
    logic [dqm_pkg::OUT_W-1:0]  row0_value;
    logic [dqm_pkg::OUT_W-1:0]  row1_value;
    logic [dqm_pkg::OUT_W-1:0]  row2_value;
    logic                       last_column;
    logic                       degenerate;
    logic                       saturated;
  } column_exp_t;
endpackage
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int LATENCY   = 30;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  dqm_in_if  in_ch();
  dqm_out_if out_ch();

  dual_quaternion_to_matrix uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  dqm_pkg::in_t            pending_q[$];   // transforms waiting for the driver
  dqm_tb_pkg::column_exp_t column_q[$];    // predicted columns, oldest first
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          in_acc = 1'b0;     // transaction taken at the last rising edge
  int          hold_cycles = 0;   // receiver hold-off, counted down by the ready process

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  // round(num * 2^15 / s), ties away from zero, clipped to 24 bits
  function automatic logic [dqm_pkg::OUT_W-1:0] scale_entry(input longint num,
                                                            input longint s,
                                                            inout logic clipped);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< dqm_pkg::FRAC) * 2 + s) / (s * 2);
    if (num >= 0) begin
      if (q > 64'sd8388607) begin
        clipped = 1'b1;
        return dqm_pkg::OUT_MAX;
      end
      return q[dqm_pkg::OUT_W-1:0];
    end
    if (q > 64'sd8388608) begin
      clipped = 1'b1;
      return dqm_pkg::OUT_MIN;
    end
    return dqm_pkg::OUT_W'(-q);
  endfunction

  // expected four columns of one transform
  task automatic predict_transform(input dqm_pkg::in_t t);
    longint w, x, y, z, dw, dx, dy, dz, s;
    longint num[4][3];
    dqm_tb_pkg::column_exp_t c;
    logic clipped;
    w = t.real_w; x = t.real_x; y = t.real_y; z = t.real_z;
    dw = t.dual_w; dx = t.dual_x; dy = t.dual_y; dz = t.dual_z;
    s = w*w + x*x + y*y + z*z;
    num[0][0] = w*w + x*x - y*y - z*z;
    num[0][1] = 2*(x*y + w*z);
    num[0][2] = 2*(x*z - w*y);
    num[1][0] = 2*(x*y - w*z);
    num[1][1] = w*w + y*y - x*x - z*z;
    num[1][2] = 2*(y*z + w*x);
    num[2][0] = 2*(x*z + w*y);
    num[2][1] = 2*(y*z - w*x);
    num[2][2] = w*w + z*z - x*x - y*y;
    num[3][0] = 2*(-dw*x + w*dx - dy*z + dz*y);
    num[3][1] = 2*(-dw*y + w*dy - dz*x + dx*z);
    num[3][2] = 2*(-dw*z + w*dz - dx*y + dy*x);
    for (int col = 0; col < 4; col++) begin
      clipped = 1'b0;
      c.column_index = col[1:0];
      c.last_column  = (col[1:0] == dqm_pkg::COL_TRANS);
      c.degenerate   = (s == 0);
      if (s == 0) begin
        // zero real part: identity rotation, zero translation
        c.row0_value = (col == 0) ? dqm_pkg::ONE_VAL : '0;
        c.row1_value = (col == 1) ? dqm_pkg::ONE_VAL : '0;
        c.row2_value = (col == 2) ? dqm_pkg::ONE_VAL : '0;
      end else begin
        c.row0_value = scale_entry(num[col][0], s, clipped);
        c.row1_value = scale_entry(num[col][1], s, clipped);
        c.row2_value = scale_entry(num[col][2], s, clipped);
      end
      c.saturated = clipped;
      column_q.push_back(c);
    end
  endtask

  function automatic dqm_pkg::in_t make_item(input int rw, rx, ry, rz, dw, dx, dy, dz);
    dqm_pkg::in_t t;
    t = '{16'(rw), 16'(rx), 16'(ry), 16'(rz), 16'(dw), 16'(dx), 16'(dy), 16'(dz)};
    return t;
  endfunction

  // small and mid-size real parts (modes 1, 3) make translation clipping show up
  function automatic logic [15:0] rand_comp(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // ---------------- driver: presents one transaction per free slot ----------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      // previous transaction taken (or none offered): maybe offer the next one
      if (pending_q.size() != 0 && !(src_idle_en && $urandom_range(0, 99) < 20)) begin
        in_ch.data  <= pending_q[0];
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // acceptance at the rising edge feeds the predictor
  always @(posedge clk) begin
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_transform(in_ch.data);
      void'(pending_q.pop_front());
    end
  end

  // ---------------- monitor: checks columns ----------------
  always @(posedge clk) begin
    dqm_tb_pkg::column_exp_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (column_q.size() == 0) begin
        report("unexpected column", out_ch.data.column_index, 0);
      end else begin
        e = column_q.pop_front();
        if (out_ch.data.column_index !== e.column_index)
          report("column_index", out_ch.data.column_index, e.column_index);
        if (out_ch.data.row0_value !== e.row0_value)
          report("row0_value", out_ch.data.row0_value, e.row0_value);
        if (out_ch.data.row1_value !== e.row1_value)
          report("row1_value", out_ch.data.row1_value, e.row1_value);
        if (out_ch.data.row2_value !== e.row2_value)
          report("row2_value", out_ch.data.row2_value, e.row2_value);
        if (out_ch.data.last_column !== e.last_column)
          report("last_column", out_ch.data.last_column, e.last_column);
        if (out_ch.data.degenerate !== e.degenerate)
          report("degenerate", out_ch.data.degenerate, e.degenerate);
        if (out_ch.data.saturated !== e.saturated)
          report("saturated", out_ch.data.saturated, e.saturated);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(sink_idle_en && $urandom_range(0, 99) < 20);
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    logic [15:0] ext[4];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero real part, unit axes, extremes, big translation
    pending_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(0, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    pending_q.push_back(make_item(16'h1000, 0, 0, 0, 0, 16'h1000, 16'h2000, 16'h3000));
    pending_q.push_back(make_item(0, 16'h1000, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(0, 0, 16'h1000, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(0, 0, 0, 16'hF000, 0, 0, 0, 0));
    pending_q.push_back(make_item(1, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_q.push_back(make_item(0, 16'hFFFF, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_q.push_back(make_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                  16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    pending_q.push_back(make_item(16'h0B50, 16'h0B50, 0, 0, 16'h0010, 16'hFFF0, 16'h0020, 0));
    pending_q.push_back(make_item(1, 1, 1, 1, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF));
    for (int i = 0; i < 8; i++)
      pending_q.push_back(make_item(ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
                                    ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
                                    ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
                                    ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)]));

    // random part, first with idling on both sides
    for (int i = 0; i < 120; i++) begin
      int m;
      m = $urandom_range(0, 3);
      pending_q.push_back(make_item(rand_comp(m), rand_comp(m), rand_comp(m), rand_comp(m),
                                    rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0)));
    end
    wait (pending_q.size() == 0);

    // sender pauses until every column is back
    wait (column_q.size() == 0);

    // receiver holds off long while the sender keeps offering: input must stall
    hold_cycles = 200;
    for (int i = 0; i < 60; i++)
      pending_q.push_back(make_item(rand_comp(3), rand_comp(3), rand_comp(1), rand_comp(0),
                                    rand_comp(0), rand_comp(2), rand_comp(0), rand_comp(1)));
    wait (pending_q.size() == 0);

    // stretch with no idling at all
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < 100; i++)
      pending_q.push_back(make_item(rand_comp(0), rand_comp(0), rand_comp(3), rand_comp(3),
                                    rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0)));
    wait (pending_q.size() == 0);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;

    for (int i = 0; i < 70; i++) begin
      int m;
      m = $urandom_range(0, 3);
      pending_q.push_back(make_item(rand_comp(m), rand_comp(1), rand_comp(m), rand_comp(0),
                                    rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0)));
    end
    wait (pending_q.size() == 0);
    wait (column_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("[dual_quaternion_to_matrix] OK");
    end else begin
      $display("[dual_quaternion_to_matrix] ERROR");
    end
    $finish;
  end

  // run limit
  always @(posedge clk) begin
    if (cycle_count == CYCLE_CAP) begin
      $display("[dual_quaternion_to_matrix] ERROR");
      $finish;
    end
  end
endmodule
`default_nettype wire
